// ===== hw/rtl/fpa_pkg.sv =====
// Shared types and operation codes for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

    typedef logic [3:0] op_t;

    localparam op_t OP_ADD      = 4'd0;
    localparam op_t OP_SUB      = 4'd1;
    localparam op_t OP_MUL      = 4'd2;
    localparam op_t OP_DIV      = 4'd3;
    localparam op_t OP_CMP      = 4'd4;
    localparam op_t OP_MIN      = 4'd5;
    localparam op_t OP_MAX      = 4'd6;
    localparam op_t OP_INC      = 4'd7;
    localparam op_t OP_DEC      = 4'd8;
    localparam op_t OP_TO_INT   = 4'd9;
    localparam op_t OP_FROM_INT = 4'd10;

    // Control carried alongside each transaction through the pipeline
    typedef struct packed {
        op_t         op;
        logic        neg;
        logic        dz;
        logic        lt;
        logic        eq;
        logic        gt;
        logic [31:0] simple;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fpa_if.sv =====
// Request and response channel interfaces for the fixed-point ALU.
`default_nettype none
interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               less_than;
    logic               equal_to;
    logic               greater_than;
    logic               overflow_flag;
    logic               divide_by_zero;

    modport source (output valid, result_value, less_than, equal_to, greater_than,
                    overflow_flag, divide_by_zero, input ready);
    modport sink   (input valid, result_value, less_than, equal_to, greater_than,
                    overflow_flag, divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpa_front.sv =====
// Entry stage: decodes simple ops, multiplies magnitudes, sets up the divider.
`default_nettype none
module fpa_front #(
    parameter int FRACTION_BITS = 8,
    parameter int W = 32 + FRACTION_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire logic [3:0]         req_type,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    valid_reg,
    output fpa_pkg::ctrl_t          ctrl_reg,
    output logic [W-1:0]            work_reg,
    output logic [31:0]             rem_reg,
    output logic [31:0]             dvs_reg,
    output logic [63:0]             prod_reg
);

    fpa_pkg::ctrl_t ctrl_next;
    logic [31:0]    mag_a;
    logic [31:0]    mag_b;

    assign mag_a = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
    assign mag_b = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

    // Results of the simple ops and compare flags
    always_comb
    begin
        ctrl_next        = '0;
        ctrl_next.op     = req_type;
        ctrl_next.neg    = operand_a[31] ^ operand_b[31];
        ctrl_next.dz     = (req_type == fpa_pkg::OP_DIV) && (operand_b == 32'sd0);
        case (req_type)
            fpa_pkg::OP_ADD:      ctrl_next.simple = operand_a + operand_b;
            fpa_pkg::OP_SUB:      ctrl_next.simple = operand_a - operand_b;
            fpa_pkg::OP_CMP:
            begin
                ctrl_next.lt = operand_a < operand_b;
                ctrl_next.eq = operand_a == operand_b;
                ctrl_next.gt = operand_a > operand_b;
            end
            fpa_pkg::OP_MIN:      ctrl_next.simple = (operand_a < operand_b) ? operand_a
                                                                             : operand_b;
            fpa_pkg::OP_MAX:      ctrl_next.simple = (operand_a > operand_b) ? operand_a
                                                                             : operand_b;
            fpa_pkg::OP_INC:      ctrl_next.simple = operand_a + 32'sd1;
            fpa_pkg::OP_DEC:      ctrl_next.simple = operand_a - 32'sd1;
            fpa_pkg::OP_TO_INT:   ctrl_next.simple = operand_a >>> FRACTION_BITS;
            fpa_pkg::OP_FROM_INT: ctrl_next.simple = operand_a << FRACTION_BITS;
            default:              ctrl_next.simple = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= ctrl_next;
            work_reg <= {mag_a, {FRACTION_BITS{1'b0}}};
            rem_reg  <= '0;
            dvs_reg  <= mag_b;
            prod_reg <= {32'd0, mag_a} * {32'd0, mag_b};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per transaction.
`default_nettype none
module fpa_div_cell #(
    parameter int W = 40
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            valid_in,
    input  wire fpa_pkg::ctrl_t  ctrl_in,
    input  wire logic [W-1:0]    work_in,
    input  wire logic [31:0]     rem_in,
    input  wire logic [31:0]     dvs_in,
    input  wire logic [63:0]     prod_in,
    output logic                 valid_reg,
    output fpa_pkg::ctrl_t       ctrl_reg,
    output logic [W-1:0]         work_reg,
    output logic [31:0]          rem_reg,
    output logic [31:0]          dvs_reg,
    output logic [63:0]          prod_reg
);

    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    // Shift next dividend bit into remainder, try subtracting divisor
    assign trial = {rem_in, work_in[W-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign qbit  = !diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= ctrl_in;
            work_reg <= {work_in[W-2:0], qbit};
            rem_reg  <= qbit ? diff[31:0] : trial[31:0];
            dvs_reg  <= dvs_in;
            prod_reg <= prod_in;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_back.sv =====
// Exit stage: scales the product, saturates, selects and registers the response.
`default_nettype none
module fpa_back #(
    parameter int FRACTION_BITS = 8,
    parameter int W = 32 + FRACTION_BITS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            valid_in,
    input  wire fpa_pkg::ctrl_t  ctrl_in,
    input  wire logic [W-1:0]    quot_in,
    input  wire logic [63:0]     prod_in,
    fpa_rsp_if.source            rsp
);

    logic [63:0] q;
    logic [31:0] sat_val;
    logic        sat_ovf;
    logic [31:0] res_next;
    logic        ovf_next;

    assign q = (ctrl_in.op == fpa_pkg::OP_MUL) ? (prod_in >> FRACTION_BITS)
                                               : 64'(quot_in);

    // Apply sign and clamp to the signed 32-bit range
    always_comb
    begin
        sat_ovf = 1'b0;
        if (ctrl_in.neg)
        begin
            if (q > 64'h0000_0000_8000_0000)
            begin
                sat_ovf = 1'b1;
                sat_val = 32'h8000_0000;
            end
            else
            begin
                sat_val = ~q[31:0] + 32'd1;
            end
        end
        else if (q > 64'h0000_0000_7FFF_FFFF)
        begin
            sat_ovf = 1'b1;
            sat_val = 32'h7FFF_FFFF;
        end
        else
        begin
            sat_val = q[31:0];
        end
    end

    always_comb
    begin
        res_next = ctrl_in.simple;
        ovf_next = 1'b0;
        if (ctrl_in.op == fpa_pkg::OP_MUL ||
            (ctrl_in.op == fpa_pkg::OP_DIV && !ctrl_in.dz))
        begin
            res_next = sat_val;
            ovf_next = sat_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.valid <= 1'b0;
        end
        else if (en)
        begin
            rsp.valid <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp.result_value   <= res_next;
            rsp.less_than      <= ctrl_in.lt;
            rsp.equal_to       <= ctrl_in.eq;
            rsp.greater_than   <= ctrl_in.gt;
            rsp.overflow_flag  <= ovf_next;
            rsp.divide_by_zero <= ctrl_in.dz;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_point_alu_top.sv =====
// Q-format fixed-point ALU: entry stage, chain of division cells, exit stage.
// Every operation passes through one entry stage, 32 + FRACTION_BITS division
//   cells at one quotient bit each, and one exit stage.
// Throughput: one transaction per cycle; the whole chain advances together and
//   stalls only when the response register is full and not taken.
// Reset: asynchronous active-low rst_n clears all valid bits; the block is ready
//   to accept requests as soon as rst_n is released.
`default_nettype none
module fixed_point_alu_top #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fpa_req_if.sink   req,
    fpa_rsp_if.source rsp
);

    localparam int W = 32 + FRACTION_BITS;

    logic           en;
    logic           v    [0:W];
    fpa_pkg::ctrl_t c    [0:W];
    logic [W-1:0]   work [0:W];
    logic [31:0]    rem  [0:W];
    logic [31:0]    dvs  [0:W];
    logic [63:0]    prod [0:W];

    // Whole pipeline moves when the response slot is free or being taken
    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS), .W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (req.valid),
        .req_type  (req.req_type),
        .operand_a (req.operand_a),
        .operand_b (req.operand_b),
        .valid_reg (v[0]),
        .ctrl_reg  (c[0]),
        .work_reg  (work[0]),
        .rem_reg   (rem[0]),
        .dvs_reg   (dvs[0]),
        .prod_reg  (prod[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        fpa_div_cell #(.W(W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v[i]),
            .ctrl_in   (c[i]),
            .work_in   (work[i]),
            .rem_in    (rem[i]),
            .dvs_in    (dvs[i]),
            .prod_in   (prod[i]),
            .valid_reg (v[i+1]),
            .ctrl_reg  (c[i+1]),
            .work_reg  (work[i+1]),
            .rem_reg   (rem[i+1]),
            .dvs_reg   (dvs[i+1]),
            .prod_reg  (prod[i+1])
        );
    end

    fpa_back #(.FRACTION_BITS(FRACTION_BITS), .W(W)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (v[W]),
        .ctrl_in  (c[W]),
        .quot_in  (work[W]),
        .prod_in  (prod[W]),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_checker.sv =====
// Port-level checker for the fixed-point ALU and its bind to the top level.
`default_nettype none
module fpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic [31:0] result_value,
    input wire logic        less_than,
    input wire logic        equal_to,
    input wire logic        greater_than,
    input wire logic        overflow_flag,
    input wire logic        divide_by_zero
);

    // A stalled response transaction stays in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(result_value))
        else $error("response changed while stalled");

    // At most one compare flag, and only with a zero result, no overflow and no divide by zero
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $onehot0({less_than, equal_to, greater_than}) &&
        (!(less_than || equal_to || greater_than) ||
         (result_value == 32'd0 && !overflow_flag && !divide_by_zero)))
        else $error("bad compare flags");

    // Divide by zero returns zero without overflow
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        valid && divide_by_zero |-> result_value == 32'd0 && !overflow_flag)
        else $error("bad divide-by-zero response");

    // Saturated results sit at a range limit
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid && overflow_flag |->
        result_value == 32'h7FFF_FFFF || result_value == 32'h8000_0000)
        else $error("overflow without saturation");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (rsp.valid),
    .ready          (rsp.ready),
    .result_value   (rsp.result_value),
    .less_than      (rsp.less_than),
    .equal_to       (rsp.equal_to),
    .greater_than   (rsp.greater_than),
    .overflow_flag  (rsp.overflow_flag),
    .divide_by_zero (rsp.divide_by_zero)
);
`default_nettype wire
